[rtl/msp_pkg.sv]
package msp_pkg;

  localparam logic [7:0] RealtimeMin = 8'hF8;
  localparam logic [7:0] SysexEnd    = 8'hF7;
  localparam logic [7:0] SysexStart  = 8'hF0;
  localparam logic [7:0] StatusBit   = 8'h80;
  localparam logic [7:0] ChanMask    = 8'h0F;
  localparam logic [7:0] SongPos     = 8'hF2;
  localparam logic [7:0] TimeCode    = 8'hF1;
  localparam logic [7:0] SongSelect  = 8'hF3;

  localparam logic [3:0] KindSysCommon = 4'd7;
  localparam logic [3:0] KindRealtime  = 4'd8;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] bytes_expected;
    logic       bytes_received;
    logic [6:0] held_data_byte;
    logic       inside_sysex;
  } parse_state_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [3:0] midi_channel;
    logic [7:0] first_value;
    logic [6:0] second_value;
  } midi_event_t;

  function automatic logic [1:0] data_count(logic [7:0] st);
    logic [1:0] cnt;
    cnt = 2'd0;
    if ((st & StatusBit) == '0) begin
      cnt = 2'd0;
    end else if (st[7:4] == 4'hC || st[7:4] == 4'hD) begin
      cnt = 2'd1;
    end else if (st[7:4] != 4'hF) begin
      cnt = 2'd2;
    end else if (st == TimeCode || st == SongSelect) begin
      cnt = 2'd1;
    end else if (st == SongPos) begin
      cnt = 2'd2;
    end
    return cnt;
  endfunction

endpackage

[rtl/msp_decode.sv]
module msp_decode
  import msp_pkg::*;
(
  input  parse_state_t state_i,
  input  logic [7:0]   byte_i,
  output parse_state_t state_o,
  output logic         emit_o,
  output midi_event_t  event_o
);

  logic [1:0] cnt;
  logic [7:0] first;
  logic [6:0] second;

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    event_o = '0;
    cnt     = data_count(byte_i);
    first   = (state_i.bytes_expected == 2'd2) ? {1'b0, state_i.held_data_byte} : byte_i;
    second  = (state_i.bytes_expected == 2'd2) ? byte_i[6:0] : 7'd0;

    if (byte_i >= RealtimeMin) begin
      emit_o              = 1'b1;
      event_o.event_kind  = KindRealtime;
      event_o.first_value = byte_i;
    end else if (state_i.inside_sysex && byte_i == SysexEnd) begin
      state_o.inside_sysex   = 1'b0;
      state_o.bytes_expected = 2'd0;
      state_o.bytes_received = 1'b0;
    end else if (state_i.inside_sysex && (byte_i & StatusBit) == '0) begin
      state_o = state_i;
    end else begin
      // a status byte inside sysex aborts it
      state_o.inside_sysex = 1'b0;
      if ((byte_i & StatusBit) != '0) begin
        state_o.running_status = byte_i;
        state_o.bytes_received = 1'b0;
        if (byte_i == SysexStart) begin
          state_o.bytes_expected = 2'd0;
          state_o.inside_sysex   = 1'b1;
        end else begin
          state_o.bytes_expected = cnt;
          if (cnt == 2'd0) begin
            state_o.running_status = '0;
            emit_o                 = 1'b1;
            event_o.event_kind     = KindSysCommon;
            event_o.first_value    = byte_i;
          end
        end
      end else if (state_i.bytes_expected == 2'd0) begin
        state_o.inside_sysex = 1'b0;
      end else if (state_i.bytes_expected == 2'd2 && !state_i.bytes_received) begin
        state_o.held_data_byte = byte_i[6:0];
        state_o.bytes_received = 1'b1;
      end else begin
        state_o.bytes_received = 1'b0;
        emit_o                 = 1'b1;
        if (state_i.running_status[7] && state_i.running_status[7:4] != 4'hF) begin
          event_o.event_kind   = {1'b0, state_i.running_status[6:4]};
          event_o.midi_channel = 4'(state_i.running_status & ChanMask);
          event_o.first_value  = first;
          event_o.second_value = second;
        end else begin
          event_o.event_kind     = KindSysCommon;
          event_o.first_value    = state_i.running_status;
          event_o.second_value   = first[6:0];
          state_o.running_status = '0;
          state_o.bytes_expected = 2'd0;
        end
      end
    end
  end

endmodule

[rtl/midi_stream_parser.sv]
// An input transfer reaches the output port through the input register, then
// decode into the result register.
// Throughput: one byte per cycle if not stalled; one decode pass per byte.
// Reset: asynchronous, active low; clears the parser state (no status,
// not in sysex) and both valid flags.
module midi_stream_parser
  import msp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] midi_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [3:0] midi_channel, [11:4] first_value,
                                       // [18:12] second_value, [23:19] zero
  output logic [3:0]  m_axis_tuser_o   // [3:0] event_kind
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  parse_state_t state_q, state_d;
  logic         out_valid_q;
  midi_event_t  out_event_q;
  logic         emit;
  midi_event_t  dec_event;
  logic         out_free;
  logic         process;

  msp_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .emit_o  (emit),
    .event_o (dec_event)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (process) begin
        state_q     <= state_d;
        out_valid_q <= emit;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (process && emit) begin
      out_event_q <= dec_event;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_event_q.event_kind;
  assign m_axis_tdata_o  = {5'd0, out_event_q.second_value, out_event_q.first_value,
                            out_event_q.midi_channel};

endmodule
